>>> design/can_isotp_segment_reassemble_core_defines.svh
// Assertion helpers shared by the checking sections of the design.
`ifndef CAN_ISOTP_SEGMENT_REASSEMBLE_CORE_DEFINES_SVH
`define CAN_ISOTP_SEGMENT_REASSEMBLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CISR_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cisr check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CISR_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cisr check failed");

`endif

>>> design/cisr_pkg.sv
package cisr_pkg;

  localparam int PosW = 12;

  localparam logic [2:0] REQ_FRAME = 3'd0;
  localparam logic [2:0] REQ_LOAD  = 3'd1;
  localparam logic [2:0] REQ_START = 3'd2;
  localparam logic [2:0] REQ_TICK  = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_MSG  = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;
  localparam logic [3:0] PCI_FC = 4'h3;

  localparam logic [3:0] FS_CTS  = 4'h0;
  localparam logic [3:0] FS_WAIT = 4'h1;
  localparam logic [3:0] FS_OVFL = 4'h2;

  localparam logic [1:0] CFG_RX_BS   = 2'd0;
  localparam logic [1:0] CFG_RX_ST   = 2'd1;
  localparam logic [1:0] CFG_FC_LIM  = 2'd2;
  localparam logic [1:0] CFG_CF_LIM  = 2'd3;

  localparam logic [2:0] FLAG_TX_ABORT = 3'b001;
  localparam logic [2:0] FLAG_RX_ABORT = 3'b010;
  localparam logic [2:0] FLAG_REJECT   = 3'b100;

  typedef enum logic [2:0] {
    OP_NONE, OP_RXW, OP_TXW, OP_RXR, OP_TXR
  } op_t;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [3:0]      frame_len;
    logic [7:0][7:0] b;
    logic [11:0]     buf_index;
    logic [11:0]     msg_len;
  } item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0][7:0] b;
    logic [11:0]     rx_msg_len;
    logic [2:0]      flags;
  } res_t;

  typedef struct packed {
    logic            we;
    logic [PosW-1:0] addr;
    logic [7:0]      wdata;
  } mem_req_t;

  function automatic logic [7:0] st_ticks(input logic [7:0] v);
    logic [7:0] r;
    if (v <= 8'h7F) r = v;
    else if (v >= 8'hF1 && v <= 8'hF9) r = 8'h00;
    else r = 8'h7F;
    return r;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

endpackage

>>> design/can_isotp_segment_reassemble_core.sv
// Flow: accept, execute, then move up to 7 buffer bytes, one byte per cycle,
//   then take in the byte read back; the result sits in the output register.
// Requests: one at a time, accepted only in idle once the last result has
//   moved on; copies use the single byte-wide port of each buffer memory.
// Reset: synchronous, clears protocol state, configuration and valid flags;
//   buffer contents are undefined until written and need no clearing pass.
`include "can_isotp_segment_reassemble_core_defines.svh"

module can_isotp_segment_reassemble_core #(
  parameter int RX_BUFFER_BYTES = 256,
  parameter int TX_BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [3:0]  frame_len,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte1,
  input  logic [7:0]  byte2,
  input  logic [7:0]  byte3,
  input  logic [7:0]  byte4,
  input  logic [7:0]  byte5,
  input  logic [7:0]  byte6,
  input  logic [7:0]  byte7,
  input  logic [11:0] buf_index,
  input  logic [11:0] msg_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic [7:0]  out_byte4,
  output logic [7:0]  out_byte5,
  output logic [7:0]  out_byte6,
  output logic [7:0]  out_byte7,
  output logic [11:0] rx_msg_len,
  output logic [2:0]  event_flags,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  cisr_pkg::item_t    item;
  cisr_pkg::res_t     res, res_q;
  cisr_pkg::mem_req_t rx_req, tx_req;
  logic [7:0]         rx_rdata, tx_rdata;
  logic               res_valid, res_free;

  assign item.req_type  = req_type;
  assign item.frame_len = frame_len;
  assign item.b         = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
  assign item.buf_index = buf_index;
  assign item.msg_len   = msg_len;

  assign res_free = !out_valid || out_ready;

  cisr_ctrl #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES),
    .TX_BUFFER_BYTES(TX_BUFFER_BYTES)
  ) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .item,
    .cfg_wr_en, .cfg_index, .cfg_data,
    .rx_req, .tx_req, .rx_rdata, .tx_rdata,
    .res_valid, .res_free, .res
  );

  cisr_ram #(.DEPTH(RX_BUFFER_BYTES)) u_rx_ram (.clk, .req(rx_req), .rdata(rx_rdata));
  cisr_ram #(.DEPTH(TX_BUFFER_BYTES)) u_tx_ram (.clk, .req(tx_req), .rdata(tx_rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_valid;
      if (res_valid) res_q <= res;
    end
  end

  assign kind        = res_q.kind;
  assign out_byte0   = res_q.b[0];
  assign out_byte1   = res_q.b[1];
  assign out_byte2   = res_q.b[2];
  assign out_byte3   = res_q.b[3];
  assign out_byte4   = res_q.b[4];
  assign out_byte5   = res_q.b[5];
  assign out_byte6   = res_q.b[6];
  assign out_byte7   = res_q.b[7];
  assign rx_msg_len  = res_q.rx_msg_len;
  assign event_flags = res_q.flags;

  `CISR_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `CISR_IMPLY(a_read_clean, out_valid && kind == cisr_pkg::KIND_READ, out_byte1 == 8'd0)
  `CISR_IMPLY(a_len_only_msg, out_valid && kind != cisr_pkg::KIND_MSG, rx_msg_len == 12'd0)
endmodule

>>> design/cisr_ram.sv
module cisr_ram #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  cisr_pkg::mem_req_t req,
  output logic [7:0]         rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.addr[AW-1:0]];
  end
endmodule

>>> design/cisr_ctrl.sv
module cisr_ctrl #(
  parameter int RX_BUFFER_BYTES = 256,
  parameter int TX_BUFFER_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cisr_pkg::item_t    item,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output cisr_pkg::mem_req_t rx_req,
  output cisr_pkg::mem_req_t tx_req,
  input  logic [7:0]         rx_rdata,
  input  logic [7:0]         tx_rdata,
  output logic               res_valid,
  input  logic               res_free,
  output cisr_pkg::res_t     res
);
  localparam logic [12:0] RxDepth = 13'(RX_BUFFER_BYTES);
  localparam logic [12:0] TxDepth = 13'(TX_BUFFER_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_COPY, S_DONE} state_t;

  state_t          state;
  cisr_pkg::item_t it;
  cisr_pkg::op_t   op;
  logic [11:0]     op_base;
  logic [2:0]      op_n, cnt, src_off, dst_off, rd_slot;
  logic            rd_pend;

  logic [7:0]  rx_block_size, rx_sep_time;
  logic [15:0] wait_fc_limit, wait_cf_limit;

  logic        rx_busy;
  logic [11:0] rx_total, rx_fill;
  logic [3:0]  rx_next_seq;
  logic [15:0] rx_idle_ticks;
  logic [7:0]  rx_block_left;
  logic [1:0]  tx_phase;
  logic [11:0] tx_total, tx_sent;
  logic [3:0]  tx_next_seq;
  logic [7:0]  tx_block, tx_block_left, tx_sep_time;
  logic [15:0] tx_fc_ticks, tx_gap_ticks;

  logic [3:0]  len, low;
  logic [11:0] ff_total, rx_rem, tx_rem, cf_fill_new, tx_sent_new;
  logic [2:0]  cf_n, tx_n;
  logic [15:0] fc_inc, gap_inc, idle_inc;
  logic [12:0] pos;
  logic        issue, pos_rx_ok, pos_tx_ok;

  always_comb begin
    len         = (it.frame_len > 4'd8) ? 4'd8 : it.frame_len;
    low         = it.b[0][3:0];
    ff_total    = {low, it.b[1]};
    rx_rem      = (rx_total > rx_fill) ? rx_total - rx_fill : 12'd0;
    cf_n        = (rx_rem > 12'd7) ? 3'd7 : rx_rem[2:0];
    cf_fill_new = rx_fill + 12'(cf_n);
    tx_rem      = (tx_total > tx_sent) ? tx_total - tx_sent : 12'd0;
    tx_n        = (tx_rem > 12'd7) ? 3'd7 : tx_rem[2:0];
    tx_sent_new = tx_sent + 12'(tx_n);
    fc_inc      = cisr_pkg::sat_inc(tx_fc_ticks);
    gap_inc     = cisr_pkg::sat_inc(tx_gap_ticks);
    idle_inc    = cisr_pkg::sat_inc(rx_idle_ticks);
    pos         = {1'b0, op_base} + 13'(cnt);
    pos_rx_ok   = pos < RxDepth;
    pos_tx_ok   = pos < TxDepth;
    issue       = (state == S_COPY) && (cnt < op_n);
  end

  always_comb begin
    rx_req.we    = issue && (op == cisr_pkg::OP_RXW) && pos_rx_ok;
    rx_req.addr  = pos[11:0];
    rx_req.wdata = it.b[src_off + cnt];
    tx_req.we    = issue && (op == cisr_pkg::OP_TXW) && pos_tx_ok;
    tx_req.addr  = pos[11:0];
    tx_req.wdata = it.b[src_off + cnt];
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rd_pend       <= 1'b0;
      rx_block_size <= 8'd0;
      rx_sep_time   <= 8'd0;
      wait_fc_limit <= 16'd1000;
      wait_cf_limit <= 16'd1000;
      rx_busy       <= 1'b0;
      rx_total      <= '0;
      rx_fill       <= '0;
      rx_next_seq   <= '0;
      rx_idle_ticks <= '0;
      rx_block_left <= '0;
      tx_phase      <= '0;
      tx_total      <= '0;
      tx_sent       <= '0;
      tx_next_seq   <= '0;
      tx_block      <= '0;
      tx_block_left <= '0;
      tx_sep_time   <= '0;
      tx_fc_ticks   <= '0;
      tx_gap_ticks  <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          cisr_pkg::CFG_RX_BS:  rx_block_size <= cfg_data[7:0];
          cisr_pkg::CFG_RX_ST:  rx_sep_time <= {1'b0, cfg_data[6:0]};
          cisr_pkg::CFG_FC_LIM: wait_fc_limit <= cfg_data;
          cisr_pkg::CFG_CF_LIM: wait_cf_limit <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            it    <= item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res     <= '0;
          op      <= cisr_pkg::OP_NONE;
          op_base <= '0;
          op_n    <= '0;
          src_off <= '0;
          dst_off <= '0;
          cnt     <= '0;
          rd_pend <= 1'b0;
          state   <= S_COPY;
          case (it.req_type)
            cisr_pkg::REQ_FRAME: begin
              if (len != 4'd0) begin
                case (it.b[0][7:4])
                  cisr_pkg::PCI_SF: begin
                    if (low != 4'd0 && low <= 4'd7 && len >= low + 4'd1) begin
                      if (rx_busy) res.flags[1] <= 1'b1;
                      rx_busy        <= 1'b0;
                      res.kind       <= cisr_pkg::KIND_MSG;
                      res.rx_msg_len <= 12'(low);
                      op             <= cisr_pkg::OP_RXW;
                      op_n           <= low[2:0];
                      src_off        <= 3'd1;
                    end
                  end
                  cisr_pkg::PCI_FF: begin
                    if (ff_total > 12'd7 && len == 4'd8) begin
                      res.kind <= cisr_pkg::KIND_FRAME;
                      if ({1'b0, ff_total} > RxDepth) begin
                        res.b[0] <= {cisr_pkg::PCI_FC, cisr_pkg::FS_OVFL};
                      end else begin
                        if (rx_busy) res.flags[1] <= 1'b1;
                        rx_total      <= ff_total;
                        rx_next_seq   <= 4'd1;
                        rx_busy       <= 1'b1;
                        rx_idle_ticks <= '0;
                        rx_block_left <= rx_block_size;
                        rx_fill       <= 12'd6;
                        res.b[0]      <= {cisr_pkg::PCI_FC, cisr_pkg::FS_CTS};
                        res.b[1]      <= rx_block_size;
                        res.b[2]      <= rx_sep_time;
                        op            <= cisr_pkg::OP_RXW;
                        op_n          <= 3'd6;
                        src_off       <= 3'd2;
                      end
                    end
                  end
                  cisr_pkg::PCI_CF: begin
                    if (rx_busy) begin
                      if (low != rx_next_seq) begin
                        rx_busy         <= 1'b0;
                        res.flags[1]    <= 1'b1;
                      end else begin
                        op            <= cisr_pkg::OP_RXW;
                        op_base       <= rx_fill;
                        op_n          <= cf_n;
                        src_off       <= 3'd1;
                        rx_fill       <= cf_fill_new;
                        rx_next_seq   <= rx_next_seq + 4'd1;
                        rx_idle_ticks <= '0;
                        if (cf_fill_new >= rx_total) begin
                          rx_busy        <= 1'b0;
                          res.kind       <= cisr_pkg::KIND_MSG;
                          res.rx_msg_len <= rx_total;
                        end else if (rx_block_left != 8'd0) begin
                          if (rx_block_left == 8'd1) begin
                            // block done: grant the next one
                            rx_block_left <= rx_block_size;
                            res.kind      <= cisr_pkg::KIND_FRAME;
                            res.b[0]      <= {cisr_pkg::PCI_FC, cisr_pkg::FS_CTS};
                            res.b[1]      <= rx_block_size;
                            res.b[2]      <= rx_sep_time;
                          end else begin
                            rx_block_left <= rx_block_left - 8'd1;
                          end
                        end
                      end
                    end
                  end
                  cisr_pkg::PCI_FC: begin
                    if (tx_phase == 2'd1) begin
                      if (low == cisr_pkg::FS_CTS) begin
                        tx_block      <= it.b[1];
                        tx_block_left <= it.b[1];
                        tx_sep_time   <= cisr_pkg::st_ticks(it.b[2]);
                        tx_phase      <= 2'd2;
                        tx_gap_ticks  <= '0;
                      end else if (low == cisr_pkg::FS_WAIT) begin
                        tx_fc_ticks <= '0;
                      end else begin
                        tx_phase     <= 2'd0;
                        res.flags[0] <= 1'b1;
                      end
                    end
                  end
                  default: ;
                endcase
              end
            end
            cisr_pkg::REQ_LOAD: begin
              op      <= cisr_pkg::OP_TXW;
              op_base <= it.buf_index;
              op_n    <= 3'd1;
            end
            cisr_pkg::REQ_START: begin
              if (it.msg_len == 12'd0 || {1'b0, it.msg_len} > TxDepth) begin
                res.flags <= cisr_pkg::FLAG_REJECT;
              end else if (it.msg_len <= 12'd7) begin
                res.kind <= cisr_pkg::KIND_FRAME;
                res.b[0] <= {4'd0, it.msg_len[3:0]};
                op       <= cisr_pkg::OP_TXR;
                op_n     <= it.msg_len[2:0];
                dst_off  <= 3'd1;
              end else if (tx_phase != 2'd0) begin
                res.flags <= cisr_pkg::FLAG_REJECT;
              end else begin
                tx_total    <= it.msg_len;
                tx_sent     <= 12'd6;
                tx_next_seq <= 4'd1;
                tx_phase    <= 2'd1;
                tx_fc_ticks <= '0;
                res.kind    <= cisr_pkg::KIND_FRAME;
                res.b[0]    <= {cisr_pkg::PCI_FF, it.msg_len[11:8]};
                res.b[1]    <= it.msg_len[7:0];
                op          <= cisr_pkg::OP_TXR;
                op_n        <= 3'd6;
                dst_off     <= 3'd2;
              end
            end
            cisr_pkg::REQ_TICK: begin
              if (tx_phase == 2'd1) begin
                tx_fc_ticks <= fc_inc;
                if (fc_inc >= wait_fc_limit) begin
                  tx_phase     <= 2'd0;
                  res.flags[0] <= 1'b1;
                end
              end
              if (tx_phase == 2'd2) begin
                if (gap_inc >= {8'd0, tx_sep_time}) begin
                  tx_gap_ticks <= '0;
                  res.kind     <= cisr_pkg::KIND_FRAME;
                  res.b[0]     <= {cisr_pkg::PCI_CF, tx_next_seq};
                  op           <= cisr_pkg::OP_TXR;
                  op_base      <= tx_sent;
                  op_n         <= tx_n;
                  dst_off      <= 3'd1;
                  tx_sent      <= tx_sent_new;
                  tx_next_seq  <= tx_next_seq + 4'd1;
                  if (tx_n == 3'd0 || tx_sent_new >= tx_total) begin
                    tx_phase <= 2'd0;
                  end else if (tx_block != 8'd0 && tx_block_left != 8'd0) begin
                    tx_block_left <= tx_block_left - 8'd1;
                    if (tx_block_left == 8'd1) begin
                      // block used up: wait for the next flow control
                      tx_phase    <= 2'd1;
                      tx_fc_ticks <= '0;
                    end
                  end
                end else begin
                  tx_gap_ticks <= gap_inc;
                end
              end
              if (rx_busy) begin
                rx_idle_ticks <= idle_inc;
                if (idle_inc >= wait_cf_limit) begin
                  rx_busy      <= 1'b0;
                  res.flags[1] <= 1'b1;
                end
              end
            end
            cisr_pkg::REQ_READ: begin
              res.kind <= cisr_pkg::KIND_READ;
              op       <= cisr_pkg::OP_RXR;
              op_base  <= it.buf_index;
              op_n     <= 3'd1;
            end
            default: ;
          endcase
        end
        S_COPY: begin
          if (issue) begin
            cnt <= cnt + 3'd1;
          end
          rd_pend <= issue && ((op == cisr_pkg::OP_RXR && pos_rx_ok) ||
                               (op == cisr_pkg::OP_TXR && pos_tx_ok));
          rd_slot <= dst_off + cnt;
          if (rd_pend) begin
            res.b[rd_slot] <= (op == cisr_pkg::OP_RXR) ? rx_rdata : tx_rdata;
          end
          if (!issue && !rd_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sim/can_isotp_segment_reassemble_core_test.sv
`timescale 1ns / 1ps

module can_isotp_segment_reassemble_core_test;
  import cisr_pkg::*;

  localparam int RX_BYTES = 256;
  localparam int TX_BYTES = 256;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 600;

  typedef enum logic [1:0] {XMT_IDLE, XMT_WAIT_FC, XMT_SEND_CF} xmt_state_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  req_type;
  logic [3:0]  frame_len;
  logic [7:0]  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;
  logic [11:0] buf_index;
  logic [11:0] msg_len;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte0, out_byte1, out_byte2, out_byte3;
  logic [7:0]  out_byte4, out_byte5, out_byte6, out_byte7;
  logic [11:0] rx_msg_len;
  logic [2:0]  event_flags;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  can_isotp_segment_reassemble_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .frame_len(frame_len),
    .byte0(byte0), .byte1(byte1), .byte2(byte2), .byte3(byte3),
    .byte4(byte4), .byte5(byte5), .byte6(byte6), .byte7(byte7),
    .buf_index(buf_index), .msg_len(msg_len),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind),
    .out_byte0(out_byte0), .out_byte1(out_byte1), .out_byte2(out_byte2),
    .out_byte3(out_byte3), .out_byte4(out_byte4), .out_byte5(out_byte5),
    .out_byte6(out_byte6), .out_byte7(out_byte7),
    .rx_msg_len(rx_msg_len), .event_flags(event_flags),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted engine state
  logic [7:0]  cfg_bs = 8'd0;
  logic [7:0]  cfg_st = 8'd0;
  logic [15:0] cfg_fc_lim = 16'd1000;
  logic [15:0] cfg_cf_lim = 16'd1000;

  logic [7:0]  rcv_mem [RX_BYTES];
  logic [7:0]  xmt_mem [TX_BYTES];
  bit          rcv_written [RX_BYTES];
  bit          xmt_written [TX_BYTES];
  bit          rcv_active = 1'b0;
  logic [11:0] rcv_total = '0;
  logic [11:0] rcv_fill = '0;
  logic [3:0]  rcv_seq = '0;
  logic [15:0] rcv_idle = '0;
  logic [7:0]  rcv_blk_left = '0;
  xmt_state_t  xmt_state = XMT_IDLE;
  logic [11:0] xmt_total = '0;
  logic [11:0] xmt_sent = '0;
  logic [3:0]  xmt_seq = '0;
  logic [7:0]  xmt_bs = '0;
  logic [7:0]  xmt_bs_left = '0;
  logic [7:0]  xmt_st = '0;
  logic [15:0] xmt_fc_wait = '0;
  logic [15:0] xmt_gap = '0;

  res_t        expect_q [$];
  res_t        got_res;
  res_t        want_res;
  int          mismatches = 0;
  int          sent_items = 0;
  int          hold_req = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic res_t flow_ctl_frame(input logic [3:0] fs, input logic [7:0] bs,
                                          input logic [7:0] st);
    res_t r;
    r = '0;
    r.kind = KIND_FRAME;
    r.b[0] = {PCI_FC, fs};
    r.b[1] = bs;
    r.b[2] = st;
    return r;
  endfunction

  function automatic res_t isotp_predict(input item_t it);
    res_t        r;
    int          flen, low, n, rem;
    logic [11:0] total;
    logic [11:0] len;
    logic [7:0]  peer_st;
    r = '0;
    case (it.req_type)
      REQ_FRAME: begin
        flen = (it.frame_len > 8) ? 8 : int'(it.frame_len);
        low = int'(it.b[0][3:0]);
        if (flen != 0) begin
          case (it.b[0][7:4])
            PCI_SF: begin
              if (low != 0 && low <= 7 && flen >= low + 1) begin
                if (rcv_active) r.flags |= FLAG_RX_ABORT;
                for (int i = 0; i < low; i++) begin
                  rcv_mem[i] = it.b[1 + i];
                  rcv_written[i] = 1'b1;
                end
                rcv_active = 1'b0;
                r.kind = KIND_MSG;
                r.rx_msg_len = 12'(low);
              end
            end
            PCI_FF: begin
              total = {it.b[0][3:0], it.b[1]};
              if (total > 7 && flen >= 8) begin
                if (total > RX_BYTES) begin
                  r = flow_ctl_frame(FS_OVFL, 8'd0, 8'd0);
                end else begin
                  r = flow_ctl_frame(FS_CTS, cfg_bs, cfg_st);
                  if (rcv_active) r.flags |= FLAG_RX_ABORT;
                  rcv_total = total;
                  rcv_seq = 4'd1;
                  rcv_active = 1'b1;
                  rcv_idle = '0;
                  rcv_blk_left = cfg_bs;
                  for (int i = 0; i < 6; i++) begin
                    rcv_mem[i] = it.b[2 + i];
                    rcv_written[i] = 1'b1;
                  end
                  rcv_fill = 12'd6;
                end
              end
            end
            PCI_CF: begin
              if (rcv_active) begin
                if (it.b[0][3:0] != rcv_seq) begin
                  rcv_active = 1'b0;
                  r.flags |= FLAG_RX_ABORT;
                end else begin
                  rem = (rcv_total > rcv_fill) ? int'(rcv_total - rcv_fill) : 0;
                  n = (rem > 7) ? 7 : rem;
                  for (int k = 0; k < n; k++) begin
                    if (int'(rcv_fill) + k < RX_BYTES) begin
                      rcv_mem[int'(rcv_fill) + k] = it.b[1 + k];
                      rcv_written[int'(rcv_fill) + k] = 1'b1;
                    end
                  end
                  rcv_fill = rcv_fill + 12'(n);
                  rcv_seq = rcv_seq + 4'd1;
                  rcv_idle = '0;
                  if (rcv_fill >= rcv_total) begin
                    rcv_active = 1'b0;
                    r.kind = KIND_MSG;
                    r.rx_msg_len = rcv_total;
                  end else if (rcv_blk_left > 0) begin
                    rcv_blk_left--;
                    if (rcv_blk_left == 0) begin
                      rcv_blk_left = cfg_bs;
                      r = flow_ctl_frame(FS_CTS, cfg_bs, cfg_st);
                    end
                  end
                end
              end
            end
            PCI_FC: begin
              if (xmt_state == XMT_WAIT_FC) begin
                if (it.b[0][3:0] == FS_CTS) begin
                  peer_st = it.b[2];
                  xmt_bs = it.b[1];
                  xmt_bs_left = it.b[1];
                  if (peer_st <= 8'h7F) xmt_st = peer_st;
                  else if (peer_st >= 8'hF1 && peer_st <= 8'hF9) xmt_st = 8'h00;
                  else xmt_st = 8'h7F;
                  xmt_state = XMT_SEND_CF;
                  xmt_gap = '0;
                end else if (it.b[0][3:0] == FS_WAIT) begin
                  xmt_fc_wait = '0;
                end else begin
                  xmt_state = XMT_IDLE;
                  r.flags |= FLAG_TX_ABORT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      REQ_LOAD: begin
        if (it.buf_index < TX_BYTES) begin
          xmt_mem[it.buf_index] = it.b[0];
          xmt_written[it.buf_index] = 1'b1;
        end
      end
      REQ_START: begin
        len = it.msg_len;
        if (len == 0 || len > TX_BYTES) begin
          r.flags |= FLAG_REJECT;
        end else if (len <= 7) begin
          r.kind = KIND_FRAME;
          r.b[0] = len[7:0];
          for (int i = 0; i < int'(len); i++) r.b[1 + i] = xmt_mem[i];
        end else if (xmt_state != XMT_IDLE) begin
          r.flags |= FLAG_REJECT;
        end else begin
          xmt_total = len;
          xmt_sent = 12'd6;
          xmt_seq = 4'd1;
          r.kind = KIND_FRAME;
          r.b[0] = {PCI_FF, len[11:8]};
          r.b[1] = len[7:0];
          for (int i = 0; i < 6; i++) r.b[2 + i] = xmt_mem[i];
          xmt_state = XMT_WAIT_FC;
          xmt_fc_wait = '0;
        end
      end
      REQ_TICK: begin
        // N_Bs first, then CF pacing, then N_Cr
        if (xmt_state == XMT_WAIT_FC) begin
          if (xmt_fc_wait != 16'hFFFF) xmt_fc_wait++;
          if (xmt_fc_wait >= cfg_fc_lim) begin
            xmt_state = XMT_IDLE;
            r.flags |= FLAG_TX_ABORT;
          end
        end
        if (xmt_state == XMT_SEND_CF) begin
          if (xmt_gap != 16'hFFFF) xmt_gap++;
          if (xmt_gap >= {8'd0, xmt_st}) begin
            rem = (xmt_total > xmt_sent) ? int'(xmt_total - xmt_sent) : 0;
            n = (rem > 7) ? 7 : rem;
            r.kind = KIND_FRAME;
            r.b[0] = {PCI_CF, xmt_seq};
            for (int i = 0; i < n; i++)
              r.b[1 + i] = (int'(xmt_sent) + i < TX_BYTES) ? xmt_mem[int'(xmt_sent) + i] : 8'h00;
            xmt_sent = xmt_sent + 12'(n);
            xmt_seq = xmt_seq + 4'd1;
            if (n == 0 || xmt_sent >= xmt_total) begin
              xmt_state = XMT_IDLE;
            end else if (xmt_bs > 0 && xmt_bs_left > 0) begin
              xmt_bs_left--;
              if (xmt_bs_left == 0) begin
                xmt_state = XMT_WAIT_FC;
                xmt_fc_wait = '0;
              end
            end
            xmt_gap = '0;
          end
        end
        if (rcv_active) begin
          if (rcv_idle != 16'hFFFF) rcv_idle++;
          if (rcv_idle >= cfg_cf_lim) begin
            rcv_active = 1'b0;
            r.flags |= FLAG_RX_ABORT;
          end
        end
      end
      REQ_READ: begin
        r.kind = KIND_READ;
        r.b[0] = (it.buf_index < RX_BYTES) ? rcv_mem[it.buf_index] : 8'h00;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.req_type = 3'($urandom_range(0, 7));
    it.frame_len = 4'($urandom);
    for (int i = 0; i < 8; i++) it.b[i] = 8'($urandom);
    it.buf_index = 12'($urandom);
    it.msg_len = 12'($urandom);
    return it;
  endfunction

  // Only touch receive entries that were written, or indexes beyond the buffer.
  function automatic logic [11:0] pick_read_index();
    logic [11:0] idx;
    if ($urandom_range(0, 4) == 0) return 12'($urandom_range(RX_BYTES, 4095));
    for (int tries = 0; tries < 64; tries++) begin
      idx = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 15)) :
                                          12'($urandom_range(0, RX_BYTES - 1));
      if (rcv_written[idx]) return idx;
    end
    return 12'($urandom_range(RX_BYTES, 4095));
  endfunction

  task automatic send_request(input item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk);
    end
    req_type = it.req_type;
    frame_len = it.frame_len;
    {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0} = it.b;
    buf_index = it.buf_index;
    msg_len = it.msg_len;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expect_q.push_back(isotp_predict(it));
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int flen, input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2);
    item_t it;
    it = random_item();
    it.req_type = REQ_FRAME;
    it.frame_len = 4'(flen);
    it.b[0] = b0;
    it.b[1] = b1;
    it.b[2] = b2;
    send_request(it);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [11:0] idx,
                         input logic [11:0] len);
    item_t it;
    it = random_item();
    it.req_type = op;
    it.buf_index = idx;
    it.msg_len = len;
    send_request(it);
  endtask

  task automatic wait_all_results();
    in_valid = 1'b0;
    while (expect_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    wait_all_results();
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_RX_BS:  cfg_bs = val[7:0];
      CFG_RX_ST:  cfg_st = {1'b0, val[6:0]};
      CFG_FC_LIM: cfg_fc_lim = val;
      CFG_CF_LIM: cfg_cf_lim = val;
      default: ;
    endcase
  endtask

  task automatic load_tx_bytes(input int len);
    for (int i = 0; i < len && i < TX_BYTES; i++)
      if (!xmt_written[i]) send_op(REQ_LOAD, 12'(i), 12'd0);
  endtask

  task automatic rx_message(input logic [11:0] total, input bit corrupt);
    int         ncf, bad_at;
    logic [3:0] seq;
    ncf = (int'(total) - 6 + 6) / 7;
    bad_at = corrupt ? $urandom_range(0, ncf - 1) : -1;
    send_frame($urandom_range(8, 15), {PCI_FF, total[11:8]}, total[7:0], 8'($urandom));
    seq = 4'd1;
    for (int s = 0; s < ncf; s++) begin
      if ($urandom_range(0, 3) == 0) send_op(REQ_TICK, 12'($urandom), 12'($urandom));
      if (s == bad_at) begin
        send_frame($urandom_range(1, 15), {PCI_CF, seq + 4'($urandom_range(1, 15))},
                   8'($urandom), 8'($urandom));
        break;
      end
      send_frame($urandom_range(1, 15), {PCI_CF, seq}, 8'($urandom), 8'($urandom));
      seq++;
    end
    repeat ($urandom_range(0, 3)) send_op(REQ_READ, pick_read_index(), 12'($urandom));
  endtask

  // Play the peer: answer each wait for flow control, tick until done.
  task automatic tx_message(input logic [11:0] len, input logic [7:0] peer_bs,
                            input logic [7:0] peer_st);
    int guard, pick;
    load_tx_bytes(int'(len));
    send_op(REQ_START, 12'($urandom), len);
    guard = 0;
    while (xmt_state != XMT_IDLE && guard < 3000) begin
      guard++;
      if (xmt_state == XMT_WAIT_FC) begin
        pick = $urandom_range(0, 19);
        if (cfg_fc_lim <= 8 && pick < 3)
          send_op(REQ_TICK, 12'($urandom), 12'($urandom));
        else if (pick == 3)
          send_frame($urandom_range(1, 15), {PCI_FC, 4'($urandom_range(2, 15))},
                     8'($urandom), 8'($urandom));
        else if (pick < 7)
          send_frame($urandom_range(1, 15), {PCI_FC, FS_WAIT}, 8'($urandom), 8'($urandom));
        else
          send_frame($urandom_range(1, 15), {PCI_FC, FS_CTS}, peer_bs, peer_st);
      end else begin
        send_op(REQ_TICK, 12'($urandom), 12'($urandom));
      end
    end
  endtask

  task automatic noise_request();
    item_t it;
    it = random_item();
    if (it.req_type == REQ_READ) it.buf_index = pick_read_index();
    if (it.req_type == REQ_FRAME && $urandom_range(0, 1) == 0) it.b[0][7:6] = 2'b00;
    if (it.req_type == REQ_START) begin
      if ($urandom_range(0, 3) != 0) it.msg_len = 12'($urandom_range(1, 40));
      load_tx_bytes(int'(it.msg_len));
    end
    send_request(it);
  endtask

  function automatic logic [7:0] random_peer_st();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(8'hF1, 8'hF9));
      1: return 8'($urandom_range(1, 3));
      default: return 8'h00;
    endcase
  endfunction

  task automatic test_directed();
    send_frame(0, 8'h03, 8'h11, 8'h22);                    // empty frame
    send_frame(15, 8'h07, 8'hFF, 8'h00);                   // SF, longest
    send_frame(8, 8'h00, 8'h55, 8'h55);                    // SF length zero
    send_frame(5, 8'h05, 8'hAA, 8'hAA);                    // SF not covered
    send_frame(8, 8'h08, 8'h01, 8'h02);                    // SF above 7
    send_frame(8, 8'hF3, 8'h01, 8'h02);                    // unused frame type
    send_frame(8, 8'h40, 8'h01, 8'h02);
    send_frame(8, {PCI_FF, 4'h0}, 8'd7, 8'h00);            // FF too short
    send_frame(7, {PCI_FF, 4'h0}, 8'd20, 8'h00);           // FF frame too short
    send_frame(8, {PCI_FF, 4'hF}, 8'hFF, 8'h00);           // overflow
    send_frame(8, {PCI_FF, 4'h1}, 8'h01, 8'h00);           // 257, overflow
    send_frame(8, {PCI_CF, 4'h1}, 8'h01, 8'h02);           // stray CF
    send_frame(3, {PCI_FC, FS_CTS}, 8'h00, 8'h00);         // stray FC
    send_op(REQ_LOAD, 12'hFFF, 12'h000);
    send_op(REQ_READ, 12'hFFF, 12'h000);
    send_op(REQ_READ, 12'd0, 12'hFFF);
    send_op(3'd5, 12'd0, 12'd0);
    send_op(3'd6, 12'd1, 12'd1);
    send_op(3'd7, 12'hFFF, 12'hFFF);
    send_op(REQ_START, 12'd0, 12'd0);
    send_op(REQ_START, 12'd0, 12'hFFF);
    send_op(REQ_START, 12'd0, 12'd257);
    load_tx_bytes(TX_BYTES);
    send_op(REQ_START, 12'd0, 12'd1);
    send_op(REQ_START, 12'd0, 12'd7);
    // interrupted reception, then a full buffer, then a sequence error
    send_frame(8, {PCI_FF, 4'h0}, 8'd20, 8'h00);
    send_frame(4, 8'h03, 8'h01, 8'h02);
    send_frame(8, {PCI_FF, 4'h0}, 8'd20, 8'h00);
    send_frame(8, {PCI_FF, 4'h0}, 8'd30, 8'h00);
    rx_message(12'd256, 1'b0);
    rx_message(12'd40, 1'b1);
    tx_message(12'd256, 8'd0, 8'd0);
    tx_message(12'd8, 8'd0, 8'h80);                        // reserved STmin
    tx_message(12'd30, 8'd2, 8'hF5);
    send_op(REQ_START, 12'd0, 12'd8);                      // peer aborts
    send_op(REQ_START, 12'd0, 12'd9);                      // rejected while busy
    send_frame(3, {PCI_FC, FS_OVFL}, 8'h00, 8'h00);
  endtask

  task automatic test_register_settings();
    write_reg(CFG_RX_BS, 16'd1);
    write_reg(CFG_RX_ST, 16'd127);
    write_reg(CFG_FC_LIM, 16'd1);
    write_reg(CFG_CF_LIM, 16'd1);
    rx_message(12'd40, 1'b0);
    tx_message(12'd30, 8'd1, 8'd0);
    write_reg(CFG_RX_BS, 16'd255);
    write_reg(CFG_RX_ST, 16'd0);
    write_reg(CFG_FC_LIM, 16'hFFFF);
    write_reg(CFG_CF_LIM, 16'hFFFF);
    rx_message(12'd256, 1'b0);
    tx_message(12'd60, 8'd255, 8'd1);
    write_reg(CFG_RX_BS, 16'd2);
    write_reg(CFG_RX_ST, 16'd85);
    write_reg(CFG_FC_LIM, 16'd3);
    write_reg(CFG_CF_LIM, 16'd4);
    rx_message(12'd60, 1'b0);
    rx_message(12'd25, 1'b0);
    tx_message(12'd40, 8'd3, 8'd0);
    send_op(REQ_START, 12'd0, 12'd20);
    repeat (4) send_op(REQ_TICK, 12'd0, 12'd0);            // no FC, N_Bs runs out
    write_reg(CFG_RX_BS, 16'd0);
    write_reg(CFG_RX_ST, 16'd0);
    write_reg(CFG_FC_LIM, 16'd1000);
    write_reg(CFG_CF_LIM, 16'd1000);
  endtask

  task automatic test_backpressure();
    hold_req = 300;
    repeat (60) begin
      if ($urandom_range(0, 1) == 0) send_op(REQ_TICK, 12'($urandom), 12'($urandom));
      else send_op(REQ_READ, pick_read_index(), 12'($urandom));
    end
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    int pick, next_cfg;
    next_cfg = sent_items + 150;
    while (sent_items < ITEM_TARGET) begin
      if (sent_items >= next_cfg) begin
        write_reg(CFG_RX_BS, 16'($urandom_range(0, 4)));
        write_reg(CFG_RX_ST, 16'($urandom_range(0, 127)));
        write_reg(CFG_FC_LIM, 16'($urandom_range(1, 30)));
        write_reg(CFG_CF_LIM, 16'($urandom_range(1, 30)));
        next_cfg = sent_items + 150;
      end
      pick = $urandom_range(0, 9);
      if (pick < 5)
        rx_message(($urandom_range(0, 7) == 0) ? 12'($urandom_range(8, 256)) :
                   12'($urandom_range(8, 40)), $urandom_range(0, 9) == 0);
      else if (pick < 8)
        tx_message(12'($urandom_range(1, 50)), 8'($urandom_range(0, 4)), random_peer_st());
      else
        noise_request();
    end
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    repeat (4) rx_message(12'($urandom_range(8, 60)), 1'b0);
    repeat (3) tx_message(12'($urandom_range(8, 60)), 8'($urandom_range(0, 3)), 8'd0);
    repeat (20) noise_request();
  endtask

  // Receiver side: random stalls plus the long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_ready = 1'b0;
        hold_req--;
      end else begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 14);
        if (stall_left > 0) begin
          out_ready = 1'b0;
          stall_left--;
        end else begin
          out_ready = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_res.kind = kind;
      got_res.b = {out_byte7, out_byte6, out_byte5, out_byte4,
                   out_byte3, out_byte2, out_byte1, out_byte0};
      got_res.rx_msg_len = rx_msg_len;
      got_res.flags = event_flags;
      if (expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d bytes %h len %0d flags %b",
                   got_res.kind, got_res.b, got_res.rx_msg_len, got_res.flags);
      end else begin
        want_res = expect_q.pop_front();
        if (got_res.kind !== want_res.kind || got_res.b !== want_res.b ||
            got_res.rx_msg_len !== want_res.rx_msg_len ||
            got_res.flags !== want_res.flags) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp kind %0d bytes %h len %0d flags %b",
                     want_res.kind, want_res.b, want_res.rx_msg_len, want_res.flags);
            $display("          got kind %0d bytes %h len %0d flags %b",
                     got_res.kind, got_res.b, got_res.rx_msg_len, got_res.flags);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("[can_isotp_segment_reassemble_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = '0;
    frame_len = '0;
    {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0} = '0;
    buf_index = '0;
    msg_len = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < RX_BYTES; i++) begin
      rcv_mem[i] = '0;
      rcv_written[i] = 1'b0;
    end
    for (int i = 0; i < TX_BYTES; i++) begin
      xmt_mem[i] = '0;
      xmt_written[i] = 1'b0;
    end
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_register_settings();
    test_backpressure();
    test_random_traffic();
    test_no_idle();
    wait_all_results();
    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("[can_isotp_segment_reassemble_core] OK");
    end else begin
      $display("[can_isotp_segment_reassemble_core] ERROR");
    end
    $finish;
  end

endmodule
